[rtl/c_subset_tokenizer_defines.svh]
// c_subset_tokenizer_defines.svh - assertion macros used by the checker file
`ifndef C_SUBSET_TOKENIZER_DEFINES_SVH
`define C_SUBSET_TOKENIZER_DEFINES_SVH

// same-cycle implication, quiet during reset
`define CST_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, quiet during reset
`define CST_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/cst_pkg.sv]
// ----------------------------------------------------------------------------
// cst_pkg
// Shared types and constants of the C subset tokenizer.
// ----------------------------------------------------------------------------
package cst_pkg;

   localparam int LINE_BITS_DEF   = 16;
   localparam int COLUMN_BITS_DEF = 12;
   localparam int KEYWORD_MAX_DEF = 8;

   // most results one source byte can cause (dot dot then unknown byte)
   localparam int RES_MAX = 5;
   localparam int CNT_W   = 3;

   typedef enum logic [3:0] {
      M_IDLE      = 4'd0,
      M_IDENT     = 4'd1,
      M_INT       = 4'd2,
      M_FRAC      = 4'd3,
      M_DOT       = 4'd4,
      M_DOTDOT    = 4'd5,
      M_STR       = 4'd6,
      M_STR_ESC   = 4'd7,
      M_CHR_FIRST = 4'd8,
      M_CHR_ESC   = 4'd9,
      M_CHR_CLOSE = 4'd10,
      M_SYM       = 4'd11
   } mode_type;

   localparam logic [5:0] TOK_INVALID    = 6'd0;
   localparam logic [5:0] TOK_END        = 6'd1;
   localparam logic [5:0] TOK_IDENT      = 6'd2;
   localparam logic [5:0] TOK_STRUCT     = 6'd3;
   localparam logic [5:0] TOK_STRING     = 6'd11;
   localparam logic [5:0] TOK_CHARLIT    = 6'd12;
   localparam logic [5:0] TOK_INT        = 6'd13;
   localparam logic [5:0] TOK_DOUBLE     = 6'd14;
   localparam logic [5:0] TOK_FLOAT      = 6'd15;
   localparam logic [5:0] TOK_ELLIPSIS   = 6'd16;
   localparam logic [5:0] TOK_DOT        = 6'd17;
   localparam logic [5:0] TOK_COMMA      = 6'd18;
   localparam logic [5:0] TOK_INCREMENT  = 6'd19;
   localparam logic [5:0] TOK_A_INCR     = 6'd20;
   localparam logic [5:0] TOK_PLUS       = 6'd21;
   localparam logic [5:0] TOK_DECREMENT  = 6'd22;
   localparam logic [5:0] TOK_A_DECR     = 6'd23;
   localparam logic [5:0] TOK_ARROW      = 6'd24;
   localparam logic [5:0] TOK_MINUS      = 6'd25;
   localparam logic [5:0] TOK_SLASH      = 6'd26;
   localparam logic [5:0] TOK_STAR       = 6'd27;
   localparam logic [5:0] TOK_PERCENT    = 6'd28;
   localparam logic [5:0] TOK_OPENPAREN  = 6'd29;
   localparam logic [5:0] TOK_CLOSEPAREN = 6'd30;
   localparam logic [5:0] TOK_OPENBRACE  = 6'd31;
   localparam logic [5:0] TOK_CLOSEBRACE = 6'd32;
   localparam logic [5:0] TOK_OPENBRACK  = 6'd33;
   localparam logic [5:0] TOK_CLOSEBRACK = 6'd34;

   // keyword text, left justified, first byte in the top byte
   localparam logic [63:0] KW_TEXT [8] = '{
      {"struct", 16'h0}, {"typedef", 8'h0}, {"float", 24'h0}, {"int", 40'h0},
      {"char", 32'h0}, {"void", 32'h0}, {"long", 32'h0}, "unsigned"
   };
   localparam logic [3:0] KW_LEN [8] = '{4'd6, 4'd7, 4'd5, 4'd3, 4'd4, 4'd4, 4'd4, 4'd8};

   // one result: kind, text byte, type, start line, start column
   function automatic int result_bits(input int lb, input int cb);
      return 1 + 8 + 6 + lb + cb;
   endfunction

   function automatic int bundle_bits(input int lb, input int cb);
      return CNT_W + RES_MAX * result_bits(lb, cb);
   endfunction

endpackage

[rtl/c_subset_tokenizer.sv]
// ----------------------------------------------------------------------------
// c_subset_tokenizer
// Streaming lexer for a small C subset, one source byte per request.
// ----------------------------------------------------------------------------
// Each request carries one source byte (0 ends the source). A byte is taken
// every cycle while the two-entry bundle queue has room; the lexer resolves
// the byte into a bundle of zero to five results. The output register then
// sends one result per cycle while the receiver does not stall. Results of a
// request come out in order and the last one has rsp_last_of_run set. Blanks
// between tokens produce no result. Token-end results carry the type and the
// start line and column; text results carry the byte after escape
// translation. Line and column saturate at all ones.
// ----------------------------------------------------------------------------
module c_subset_tokenizer #(
   parameter int LINE_BITS   = cst_pkg::LINE_BITS_DEF,
   parameter int COLUMN_BITS = cst_pkg::COLUMN_BITS_DEF,
   parameter int KEYWORD_MAX = cst_pkg::KEYWORD_MAX_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [7:0] req_source_char,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic rsp_result_kind,
   output logic [7:0] rsp_text_char,
   output logic [5:0] rsp_token_type,
   output logic [LINE_BITS-1:0] rsp_token_line,
   output logic [COLUMN_BITS-1:0] rsp_token_column,
   output logic rsp_last_of_run
);
   import cst_pkg::*;

   localparam int BW = bundle_bits(LINE_BITS, COLUMN_BITS);

   logic          accept;
   logic          push, pop, full, not_empty;
   logic [BW-1:0] bundle, head;

   // stall only while both bundle slots are taken
   assign req_stall = full;
   assign accept    = req_valid && !full;

   cst_front #(
      .LINE_BITS   (LINE_BITS),
      .COLUMN_BITS (COLUMN_BITS),
      .KEYWORD_MAX (KEYWORD_MAX)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .source_char (req_source_char),
      .push        (push),
      .bundle      (bundle)
   );

   cst_queue #(
      .WIDTH (BW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (bundle),
      .pop       (pop),
      .full      (full),
      .not_empty (not_empty),
      .head      (head)
   );

   cst_back #(
      .LINE_BITS   (LINE_BITS),
      .COLUMN_BITS (COLUMN_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (not_empty),
      .q_head           (head),
      .q_pop            (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_text_char    (rsp_text_char),
      .rsp_token_type   (rsp_token_type),
      .rsp_token_line   (rsp_token_line),
      .rsp_token_column (rsp_token_column),
      .rsp_last_of_run  (rsp_last_of_run)
   );

endmodule

[rtl/cst_front.sv]
// ----------------------------------------------------------------------------
// cst_front
// Lexer state machine: classifies one source byte per accepted request and
// produces the bundle of results it causes, plus position tracking.
// ----------------------------------------------------------------------------
module cst_front #(
   parameter int LINE_BITS   = cst_pkg::LINE_BITS_DEF,
   parameter int COLUMN_BITS = cst_pkg::COLUMN_BITS_DEF,
   parameter int KEYWORD_MAX = cst_pkg::KEYWORD_MAX_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic accept,
   input  logic [7:0] source_char,
   output logic push,
   output logic [cst_pkg::bundle_bits(LINE_BITS, COLUMN_BITS)-1:0] bundle
);
   import cst_pkg::*;

   localparam int KW_IDX = $clog2(KEYWORD_MAX);

   typedef struct packed {
      logic                   kind;
      logic [7:0]             ch;
      logic [5:0]             ttype;
      logic [LINE_BITS-1:0]   line;
      logic [COLUMN_BITS-1:0] col;
   } result_type;

   typedef struct packed {
      logic [CNT_W-1:0]             count;
      result_type [RES_MAX-1:0]     res;
   } bundle_type;

   localparam logic [LINE_BITS-1:0]   LINE_TOP = '1;
   localparam logic [COLUMN_BITS-1:0] COL_TOP  = '1;
   localparam logic [LINE_BITS-1:0]   LINE_ONE = LINE_BITS'(1);
   localparam logic [COLUMN_BITS-1:0] COL_ONE  = COLUMN_BITS'(1);

   mode_type                    mode_ff, mode_in;
   logic [LINE_BITS-1:0]        line_ff, line_in, sline_ff, sline_in;
   logic [COLUMN_BITS-1:0]      col_ff, col_in, scol_ff, scol_in;
   logic [3:0]                  idlen_ff, idlen_in;
   logic [7:0]                  pend_ff, pend_in;
   logic [KEYWORD_MAX-1:0][7:0] win_ff, win_in;
   bundle_type                  bnd;
   logic                        done;

   function automatic logic is_alpha(input logic [7:0] c);
      logic [7:0] l;
      l = c | 8'h20;
      return (l >= "a") && (l <= "z");
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic [7:0] esc_of(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c == "n") r = 8'h0a;
      else if (c == "t") r = 8'h09;
      else if (c == "r") r = 8'h0d;
      return r;
   endfunction

   function automatic logic [5:0] sym_code(input logic [7:0] c);
      logic [5:0] t;
      unique case (c)
         ",": t = TOK_COMMA;
         "/": t = TOK_SLASH;
         "*": t = TOK_STAR;
         "%": t = TOK_PERCENT;
         "(": t = TOK_OPENPAREN;
         ")": t = TOK_CLOSEPAREN;
         "{": t = TOK_OPENBRACE;
         "}": t = TOK_CLOSEBRACE;
         "[": t = TOK_OPENBRACK;
         "]": t = TOK_CLOSEBRACK;
         default: t = TOK_INVALID;
      endcase
      return t;
   endfunction

   function automatic logic [5:0] ident_code(input logic [3:0] len,
                                             input logic [KEYWORD_MAX-1:0][7:0] w);
      logic [5:0] r;
      logic       hit;
      r = TOK_IDENT;
      for (int k = 7; k >= 0; k--) begin
         hit = (len == KW_LEN[k]);
         for (int j = 0; j < 8; j++) begin
            if ((4'(j) < KW_LEN[k]) && (w[KW_IDX'(j)] != KW_TEXT[k][63-8*j -: 8])) hit = 1'b0;
         end
         if (hit) r = TOK_STRUCT + 6'(k);
      end
      return r;
   endfunction

   function automatic result_type mk(input logic kind, input logic [7:0] ch,
                                     input logic [5:0] t, input logic [LINE_BITS-1:0] l,
                                     input logic [COLUMN_BITS-1:0] c);
      result_type r;
      r.kind  = kind;
      r.ch    = ch;
      r.ttype = t;
      r.line  = l;
      r.col   = c;
      return r;
   endfunction

   // up to three passes: dot-dot falls back to dot, which may fall back to idle
   always_comb begin
      mode_in  = mode_ff;
      line_in  = line_ff;
      col_in   = col_ff;
      sline_in = sline_ff;
      scol_in  = scol_ff;
      idlen_in = idlen_ff;
      pend_in  = pend_ff;
      win_in   = win_ff;
      bnd      = '0;
      done     = 1'b0;
      for (int p = 0; p < 3; p++) begin
         if (!done) begin
            unique case (mode_in)
               M_IDLE: begin
                  done = 1'b1;
                  if (source_char == 8'h00) begin
                     bnd.res[bnd.count] = mk(1'b1, 8'h00, TOK_END, line_in, col_in);
                     bnd.count = bnd.count + 1'b1;
                     line_in  = LINE_ONE;
                     col_in   = COL_ONE;
                     sline_in = LINE_ONE;
                     scol_in  = COL_ONE;
                  end else if (!(source_char == " " || source_char == 8'h09 ||
                                 source_char == 8'h0d || source_char == 8'h0a)) begin
                     sline_in = line_in;
                     scol_in  = col_in;
                     if (source_char == 8'h22) begin
                        mode_in = M_STR;
                     end else if (source_char == 8'h27) begin
                        mode_in = M_CHR_FIRST;
                     end else if (is_alpha(source_char) || source_char == "_") begin
                        bnd.res[bnd.count] = mk(1'b0, source_char, TOK_INVALID, sline_in, scol_in);
                        bnd.count = bnd.count + 1'b1;
                        win_in[0] = source_char;
                        idlen_in  = 4'd1;
                        mode_in   = M_IDENT;
                     end else if (is_digit(source_char)) begin
                        bnd.res[bnd.count] = mk(1'b0, source_char, TOK_INVALID, sline_in, scol_in);
                        bnd.count = bnd.count + 1'b1;
                        mode_in = M_INT;
                     end else if (source_char == ".") begin
                        bnd.res[bnd.count] = mk(1'b0, source_char, TOK_INVALID, sline_in, scol_in);
                        bnd.count = bnd.count + 1'b1;
                        mode_in = M_DOT;
                     end else if (source_char == "+" || source_char == "-") begin
                        bnd.res[bnd.count] = mk(1'b0, source_char, TOK_INVALID, sline_in, scol_in);
                        bnd.count = bnd.count + 1'b1;
                        pend_in = source_char;
                        mode_in = M_SYM;
                     end else begin
                        bnd.res[bnd.count] = mk(1'b0, source_char, TOK_INVALID, sline_in, scol_in);
                        bnd.count = bnd.count + 1'b1;
                        bnd.res[bnd.count] = mk(1'b1, 8'h00, sym_code(source_char),
                                                sline_in, scol_in);
                        bnd.count = bnd.count + 1'b1;
                     end
                  end
               end
               M_IDENT: begin
                  if (is_alpha(source_char) || is_digit(source_char) || source_char == "_") begin
                     bnd.res[bnd.count] = mk(1'b0, source_char, TOK_INVALID, sline_in, scol_in);
                     bnd.count = bnd.count + 1'b1;
                     if (5'(idlen_in) < 5'(KEYWORD_MAX)) win_in[idlen_in[KW_IDX-1:0]] = source_char;
                     if (idlen_in != 4'd15) idlen_in = idlen_in + 4'd1;
                     done = 1'b1;
                  end else begin
                     bnd.res[bnd.count] = mk(1'b1, 8'h00, ident_code(idlen_in, win_in),
                                             sline_in, scol_in);
                     bnd.count = bnd.count + 1'b1;
                     mode_in = M_IDLE;
                  end
               end
               M_INT, M_FRAC: begin
                  if (is_digit(source_char)) begin
                     bnd.res[bnd.count] = mk(1'b0, source_char, TOK_INVALID, sline_in, scol_in);
                     bnd.count = bnd.count + 1'b1;
                     done = 1'b1;
                  end else if (source_char == "." && mode_in == M_INT) begin
                     bnd.res[bnd.count] = mk(1'b0, source_char, TOK_INVALID, sline_in, scol_in);
                     bnd.count = bnd.count + 1'b1;
                     mode_in = M_FRAC;
                     done = 1'b1;
                  end else if (source_char == "f" || source_char == "F") begin
                     bnd.res[bnd.count] = mk(1'b0, source_char, TOK_INVALID, sline_in, scol_in);
                     bnd.count = bnd.count + 1'b1;
                     bnd.res[bnd.count] = mk(1'b1, 8'h00, TOK_FLOAT, sline_in, scol_in);
                     bnd.count = bnd.count + 1'b1;
                     mode_in = M_IDLE;
                     done = 1'b1;
                  end else begin
                     bnd.res[bnd.count] = mk(1'b1, 8'h00,
                                             (mode_in == M_INT) ? TOK_INT : TOK_DOUBLE,
                                             sline_in, scol_in);
                     bnd.count = bnd.count + 1'b1;
                     mode_in = M_IDLE;
                  end
               end
               M_DOT: begin
                  if (is_digit(source_char)) begin
                     bnd.res[bnd.count] = mk(1'b0, source_char, TOK_INVALID, sline_in, scol_in);
                     bnd.count = bnd.count + 1'b1;
                     mode_in = M_FRAC;
                     done = 1'b1;
                  end else if (source_char == ".") begin
                     mode_in = M_DOTDOT;
                     done = 1'b1;
                  end else begin
                     bnd.res[bnd.count] = mk(1'b1, 8'h00, TOK_DOT, sline_in, scol_in);
                     bnd.count = bnd.count + 1'b1;
                     mode_in = M_IDLE;
                  end
               end
               M_DOTDOT: begin
                  if (source_char == ".") begin
                     bnd.res[bnd.count] = mk(1'b0, ".", TOK_INVALID, sline_in, scol_in);
                     bnd.count = bnd.count + 1'b1;
                     bnd.res[bnd.count] = mk(1'b0, ".", TOK_INVALID, sline_in, scol_in);
                     bnd.count = bnd.count + 1'b1;
                     bnd.res[bnd.count] = mk(1'b1, 8'h00, TOK_ELLIPSIS, sline_in, scol_in);
                     bnd.count = bnd.count + 1'b1;
                     mode_in = M_IDLE;
                     done = 1'b1;
                  end else begin
                     // close the first dot, second dot starts a new token
                     bnd.res[bnd.count] = mk(1'b1, 8'h00, TOK_DOT, sline_in, scol_in);
                     bnd.count = bnd.count + 1'b1;
                     if (scol_in != COL_TOP) scol_in = scol_in + COL_ONE;
                     bnd.res[bnd.count] = mk(1'b0, ".", TOK_INVALID, sline_in, scol_in);
                     bnd.count = bnd.count + 1'b1;
                     mode_in = M_DOT;
                  end
               end
               M_STR: begin
                  if (source_char == 8'h22) begin
                     bnd.res[bnd.count] = mk(1'b1, 8'h00, TOK_STRING, sline_in, scol_in);
                     bnd.count = bnd.count + 1'b1;
                     mode_in = M_IDLE;
                     done = 1'b1;
                  end else if (source_char == 8'h5c) begin
                     mode_in = M_STR_ESC;
                     done = 1'b1;
                  end else if (source_char == 8'h00) begin
                     bnd.res[bnd.count] = mk(1'b1, 8'h00, TOK_INVALID, sline_in, scol_in);
                     bnd.count = bnd.count + 1'b1;
                     mode_in = M_IDLE;
                  end else begin
                     bnd.res[bnd.count] = mk(1'b0, source_char, TOK_INVALID, sline_in, scol_in);
                     bnd.count = bnd.count + 1'b1;
                     done = 1'b1;
                  end
               end
               M_STR_ESC, M_CHR_ESC: begin
                  if (source_char == 8'h00) begin
                     bnd.res[bnd.count] = mk(1'b1, 8'h00, TOK_INVALID, sline_in, scol_in);
                     bnd.count = bnd.count + 1'b1;
                     mode_in = M_IDLE;
                  end else begin
                     bnd.res[bnd.count] = mk(1'b0, esc_of(source_char), TOK_INVALID,
                                             sline_in, scol_in);
                     bnd.count = bnd.count + 1'b1;
                     mode_in = (mode_in == M_STR_ESC) ? M_STR : M_CHR_CLOSE;
                     done = 1'b1;
                  end
               end
               M_CHR_FIRST: begin
                  if (source_char == 8'h00) begin
                     bnd.res[bnd.count] = mk(1'b1, 8'h00, TOK_INVALID, sline_in, scol_in);
                     bnd.count = bnd.count + 1'b1;
                     mode_in = M_IDLE;
                  end else if (source_char == 8'h5c) begin
                     mode_in = M_CHR_ESC;
                     done = 1'b1;
                  end else begin
                     bnd.res[bnd.count] = mk(1'b0, source_char, TOK_INVALID, sline_in, scol_in);
                     bnd.count = bnd.count + 1'b1;
                     mode_in = M_CHR_CLOSE;
                     done = 1'b1;
                  end
               end
               M_CHR_CLOSE: begin
                  if (source_char == 8'h27) begin
                     bnd.res[bnd.count] = mk(1'b1, 8'h00, TOK_CHARLIT, sline_in, scol_in);
                     bnd.count = bnd.count + 1'b1;
                     done = 1'b1;
                  end else begin
                     bnd.res[bnd.count] = mk(1'b1, 8'h00, TOK_INVALID, sline_in, scol_in);
                     bnd.count = bnd.count + 1'b1;
                  end
                  mode_in = M_IDLE;
               end
               M_SYM: begin
                  if (pend_in == "+" && (source_char == "+" || source_char == "=")) begin
                     bnd.res[bnd.count] = mk(1'b0, source_char, TOK_INVALID, sline_in, scol_in);
                     bnd.count = bnd.count + 1'b1;
                     bnd.res[bnd.count] = mk(1'b1, 8'h00,
                                             (source_char == "+") ? TOK_INCREMENT : TOK_A_INCR,
                                             sline_in, scol_in);
                     bnd.count = bnd.count + 1'b1;
                     done = 1'b1;
                  end else if (pend_in != "+" && (source_char == "-" || source_char == "=" ||
                                                  source_char == ">")) begin
                     bnd.res[bnd.count] = mk(1'b0, source_char, TOK_INVALID, sline_in, scol_in);
                     bnd.count = bnd.count + 1'b1;
                     bnd.res[bnd.count] = mk(1'b1, 8'h00,
                                             (source_char == "-") ? TOK_DECREMENT :
                                             (source_char == "=") ? TOK_A_DECR : TOK_ARROW,
                                             sline_in, scol_in);
                     bnd.count = bnd.count + 1'b1;
                     done = 1'b1;
                  end else begin
                     bnd.res[bnd.count] = mk(1'b1, 8'h00,
                                             (pend_in == "+") ? TOK_PLUS : TOK_MINUS,
                                             sline_in, scol_in);
                     bnd.count = bnd.count + 1'b1;
                  end
                  mode_in = M_IDLE;
               end
               default: begin
                  mode_in = M_IDLE;
               end
            endcase
         end
      end
      // position of the next byte
      if (source_char == 8'h0a) begin
         if (line_in != LINE_TOP) line_in = line_in + LINE_ONE;
         col_in = COL_ONE;
      end else if (source_char != 8'h00) begin
         if (col_in != COL_TOP) col_in = col_in + COL_ONE;
      end
   end

   assign push   = accept && (bnd.count != '0);
   assign bundle = bnd;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= M_IDLE;
         line_ff  <= LINE_ONE;
         col_ff   <= COL_ONE;
         sline_ff <= LINE_ONE;
         scol_ff  <= COL_ONE;
         idlen_ff <= '0;
         pend_ff  <= '0;
      end else if (accept) begin
         mode_ff  <= mode_in;
         line_ff  <= line_in;
         col_ff   <= col_in;
         sline_ff <= sline_in;
         scol_ff  <= scol_in;
         idlen_ff <= idlen_in;
         pend_ff  <= pend_in;
      end
   end

   // identifier bytes, read only after written within the same identifier
   always_ff @(posedge clock) begin
      if (accept) begin
         win_ff <= win_in;
      end
   end

endmodule

[rtl/cst_queue.sv]
// ----------------------------------------------------------------------------
// cst_queue
// Two-entry queue of result bundles between the lexer and the output side.
// ----------------------------------------------------------------------------
module cst_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic             full,
   output logic             not_empty,
   output logic [WIDTH-1:0] head
);
   logic [WIDTH-1:0] slot_ff [2];
   logic             wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0]       cnt_ff, cnt_in;

   assign full      = (cnt_ff == 2'd2);
   assign not_empty = (cnt_ff != 2'd0);
   assign head      = slot_ff[rd_ff];

   always_comb begin
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

endmodule

[rtl/cst_back.sv]
// ----------------------------------------------------------------------------
// cst_back
// Output side: walks the head bundle into the response register one result
// per cycle while rsp_stall is low, and marks the last result of each request.
// ----------------------------------------------------------------------------
module cst_back #(
   parameter int LINE_BITS   = cst_pkg::LINE_BITS_DEF,
   parameter int COLUMN_BITS = cst_pkg::COLUMN_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic q_valid,
   input  logic [cst_pkg::bundle_bits(LINE_BITS, COLUMN_BITS)-1:0] q_head,
   output logic q_pop,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic rsp_result_kind,
   output logic [7:0] rsp_text_char,
   output logic [5:0] rsp_token_type,
   output logic [LINE_BITS-1:0] rsp_token_line,
   output logic [COLUMN_BITS-1:0] rsp_token_column,
   output logic rsp_last_of_run
);
   import cst_pkg::*;

   typedef struct packed {
      logic                   kind;
      logic [7:0]             ch;
      logic [5:0]             ttype;
      logic [LINE_BITS-1:0]   line;
      logic [COLUMN_BITS-1:0] col;
   } result_type;

   typedef struct packed {
      logic [CNT_W-1:0]         count;
      result_type [RES_MAX-1:0] res;
   } bundle_type;

   bundle_type       hd;
   result_type       cur;
   logic             load, last;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic             valid_ff;
   result_type       out_ff;
   logic             last_ff;

   assign hd    = q_head;
   assign cur   = hd.res[idx_ff];
   assign load  = q_valid && (!valid_ff || !rsp_stall);
   assign last  = (idx_ff + 1'b1) == hd.count;
   assign q_pop = load && last;

   always_comb begin
      idx_in = idx_ff;
      if (load) begin
         idx_in = last ? '0 : idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         idx_ff <= idx_in;
         if (load) valid_ff <= 1'b1;
         else if (!rsp_stall) valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_ff  <= cur;
         last_ff <= last;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_result_kind  = out_ff.kind;
   assign rsp_text_char    = out_ff.ch;
   assign rsp_token_type   = out_ff.ttype;
   assign rsp_token_line   = out_ff.line;
   assign rsp_token_column = out_ff.col;
   assign rsp_last_of_run  = last_ff;

endmodule

[rtl/cst_checker.sv]
// ----------------------------------------------------------------------------
// cst_checker
// Port-level checks of the tokenizer response stream.
// ----------------------------------------------------------------------------
`include "c_subset_tokenizer_defines.svh"

module cst_checker #(
   parameter int LINE_BITS   = cst_pkg::LINE_BITS_DEF,
   parameter int COLUMN_BITS = cst_pkg::COLUMN_BITS_DEF
) (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_result_kind,
   input logic [7:0] rsp_text_char,
   input logic [5:0] rsp_token_type,
   input logic [LINE_BITS-1:0] rsp_token_line,
   input logic [COLUMN_BITS-1:0] rsp_token_column,
   input logic rsp_last_of_run
);
   import cst_pkg::*;

   `CST_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable({rsp_result_kind, rsp_text_char, rsp_token_type, rsp_token_line, rsp_token_column, rsp_last_of_run}), "response changed while stalled")
   `CST_ASSERT_NOW(a_text_type, clock, reset, rsp_valid && !rsp_result_kind, rsp_token_type == TOK_INVALID, "text result with a token type")
   `CST_ASSERT_NOW(a_end_char, clock, reset, rsp_valid && rsp_result_kind, rsp_text_char == 8'h00, "token end with a text byte")
   `CST_ASSERT_NOW(a_pos_nonzero, clock, reset, rsp_valid, rsp_token_line != '0 && rsp_token_column != '0, "zero start position")

endmodule

bind c_subset_tokenizer cst_checker #(
   .LINE_BITS   (LINE_BITS),
   .COLUMN_BITS (COLUMN_BITS)
) u_cst_checker (.*);

[verif/c_subset_tokenizer_tb.sv]
// ----------------------------------------------------------------------------
// c_subset_tokenizer_tb
// Self-checking bench for the C subset tokenizer.
// ----------------------------------------------------------------------------
// Source bytes are pushed one request at a time. Each accepted byte runs
// through a behavioral lexer kept in this bench, and the lexer queues the
// token text and token-end results that the byte should cause. A checker
// process compares every accepted result, field by field, with the oldest
// queued one. Directed sources cover keywords, literals, escapes, every
// punctuator and broken tokens. Random token streams follow under three
// sender/receiver idling mixes.
// ----------------------------------------------------------------------------
module c_subset_tokenizer_tb;
   import cst_pkg::*;

   typedef struct packed {
      logic        kind;
      logic [7:0]  ch;
      logic [5:0]  tok;
      logic [15:0] line;
      logic [11:0] col;
      logic        last;
   } lex_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_source_char = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_result_kind;
   logic [7:0]  rsp_text_char;
   logic [5:0]  rsp_token_type;
   logic [15:0] rsp_token_line;
   logic [11:0] rsp_token_column;
   logic        rsp_last_of_run;

   c_subset_tokenizer uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_source_char(req_source_char),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_result_kind(rsp_result_kind), .rsp_text_char(rsp_text_char),
      .rsp_token_type(rsp_token_type), .rsp_token_line(rsp_token_line),
      .rsp_token_column(rsp_token_column), .rsp_last_of_run(rsp_last_of_run)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // hard stop, far beyond the slowest correct run
   initial begin
      #20_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // ------------------------------------------------------------------
   // behavioral lexer state
   // ------------------------------------------------------------------
   mode_type    lx_mode = M_IDLE;
   logic [15:0] lx_line = 16'd1, lx_sline = 16'd1;
   logic [11:0] lx_col = 12'd1, lx_scol = 12'd1;
   logic [7:0]  kw_win [8];
   logic [3:0]  id_len = 4'd0;
   logic [7:0]  sym_held = 8'h00;

   lex_result_type tokens_due[$];   // results still owed by the block
   int          mismatches = 0;
   int          chars_sent = 0;
   int          results_seen = 0;
   int          tokens_seen = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;

   string       keywords [8] = '{"struct", "typedef", "float", "int",
                                 "char", "void", "long", "unsigned"};

   function automatic void push_result(logic kind, logic [7:0] ch, logic [5:0] tok);
      lex_result_type r;
      r.kind = kind;
      r.ch   = ch;
      r.tok  = tok;
      r.line = lx_sline;
      r.col  = lx_scol;
      r.last = 1'b0;
      tokens_due.push_back(r);
   endfunction

   function automatic logic is_letter(logic [7:0] c);
      logic [7:0] l;
      l = c | 8'h20;
      return l >= "a" && l <= "z";
   endfunction

   function automatic logic is_num(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic [7:0] unescape(logic [7:0] c);
      if (c == "n") return 8'h0a;
      if (c == "t") return 8'h09;
      if (c == "r") return 8'h0d;
      return c;
   endfunction

   function automatic logic [5:0] ident_class();
      string s;
      s = "";
      for (int i = 0; i < 8 && i < id_len; i++) s = {s, string'(kw_win[i])};
      for (int k = 0; k < 8; k++)
         if (id_len == keywords[k].len() && s == keywords[k]) return TOK_STRUCT + 6'(k);
      return TOK_IDENT;
   endfunction

   function automatic void mark_start();
      lx_sline = lx_line;
      lx_scol  = lx_col;
   endfunction

   // one pass of the lexer over byte c; 0 means feed c again
   function automatic logic lex_pass(logic [7:0] c);
      logic [5:0] t;
      case (lx_mode)
         M_IDLE: begin
            if (c == 8'h00) begin
               mark_start();
               push_result(1'b1, 8'h00, TOK_END);
               lx_line = 1; lx_col = 1; lx_sline = 1; lx_scol = 1;
               return 1'b1;
            end
            if (c == " " || c == 8'h09 || c == 8'h0d || c == 8'h0a) return 1'b1;
            mark_start();
            if (c == "\"") begin lx_mode = M_STR; return 1'b1; end
            if (c == "'") begin lx_mode = M_CHR_FIRST; return 1'b1; end
            if (is_letter(c) || c == "_") begin
               push_result(1'b0, c, 6'd0);
               kw_win[0] = c;
               id_len = 1;
               lx_mode = M_IDENT;
               return 1'b1;
            end
            if (is_num(c)) begin push_result(1'b0, c, 6'd0); lx_mode = M_INT; return 1'b1; end
            if (c == ".") begin push_result(1'b0, c, 6'd0); lx_mode = M_DOT; return 1'b1; end
            if (c == "+" || c == "-") begin
               push_result(1'b0, c, 6'd0);
               sym_held = c;
               lx_mode = M_SYM;
               return 1'b1;
            end
            case (c)
               ",":     t = TOK_COMMA;
               "/":     t = TOK_SLASH;
               "*":     t = TOK_STAR;
               "%":     t = TOK_PERCENT;
               "(":     t = TOK_OPENPAREN;
               ")":     t = TOK_CLOSEPAREN;
               "{":     t = TOK_OPENBRACE;
               "}":     t = TOK_CLOSEBRACE;
               "[":     t = TOK_OPENBRACK;
               "]":     t = TOK_CLOSEBRACK;
               default: t = TOK_INVALID;
            endcase
            push_result(1'b0, c, 6'd0);
            push_result(1'b1, 8'h00, t);
            return 1'b1;
         end
         M_IDENT: begin
            if (is_letter(c) || is_num(c) || c == "_") begin
               push_result(1'b0, c, 6'd0);
               if (id_len < 8) kw_win[id_len[2:0]] = c;
               if (id_len < 15) id_len++;
               return 1'b1;
            end
            push_result(1'b1, 8'h00, ident_class());
         end
         M_INT, M_FRAC: begin
            if (is_num(c)) begin push_result(1'b0, c, 6'd0); return 1'b1; end
            if (c == "." && lx_mode == M_INT) begin
               push_result(1'b0, c, 6'd0);
               lx_mode = M_FRAC;
               return 1'b1;
            end
            if (c == "f" || c == "F") begin
               push_result(1'b0, c, 6'd0);
               push_result(1'b1, 8'h00, TOK_FLOAT);
               lx_mode = M_IDLE;
               return 1'b1;
            end
            push_result(1'b1, 8'h00, lx_mode == M_INT ? TOK_INT : TOK_DOUBLE);
         end
         M_DOT: begin
            if (is_num(c)) begin push_result(1'b0, c, 6'd0); lx_mode = M_FRAC; return 1'b1; end
            if (c == ".") begin lx_mode = M_DOTDOT; return 1'b1; end
            push_result(1'b1, 8'h00, TOK_DOT);
         end
         M_DOTDOT: begin
            if (c == ".") begin
               push_result(1'b0, ".", 6'd0);
               push_result(1'b0, ".", 6'd0);
               push_result(1'b1, 8'h00, TOK_ELLIPSIS);
               lx_mode = M_IDLE;
               return 1'b1;
            end
            // ".." then other: DOT, and the second dot opens a new token
            push_result(1'b1, 8'h00, TOK_DOT);
            if (lx_scol != 12'hfff) lx_scol++;
            push_result(1'b0, ".", 6'd0);
            lx_mode = M_DOT;
            return 1'b0;
         end
         M_STR: begin
            if (c == "\"") begin push_result(1'b1, 8'h00, TOK_STRING); lx_mode = M_IDLE; return 1'b1; end
            if (c == "\\") begin lx_mode = M_STR_ESC; return 1'b1; end
            if (c == 8'h00) push_result(1'b1, 8'h00, TOK_INVALID);
            else begin push_result(1'b0, c, 6'd0); return 1'b1; end
         end
         M_STR_ESC: begin
            if (c == 8'h00) push_result(1'b1, 8'h00, TOK_INVALID);
            else begin push_result(1'b0, unescape(c), 6'd0); lx_mode = M_STR; return 1'b1; end
         end
         M_CHR_FIRST: begin
            if (c == 8'h00) push_result(1'b1, 8'h00, TOK_INVALID);
            else if (c == "\\") begin lx_mode = M_CHR_ESC; return 1'b1; end
            else begin push_result(1'b0, c, 6'd0); lx_mode = M_CHR_CLOSE; return 1'b1; end
         end
         M_CHR_ESC: begin
            if (c == 8'h00) push_result(1'b1, 8'h00, TOK_INVALID);
            else begin
               push_result(1'b0, unescape(c), 6'd0);
               lx_mode = M_CHR_CLOSE;
               return 1'b1;
            end
         end
         M_CHR_CLOSE: begin
            if (c == "'") begin push_result(1'b1, 8'h00, TOK_CHARLIT); lx_mode = M_IDLE; return 1'b1; end
            push_result(1'b1, 8'h00, TOK_INVALID);
         end
         M_SYM: begin
            if (sym_held == "+") begin
               if (c == "+" || c == "=") begin
                  push_result(1'b0, c, 6'd0);
                  push_result(1'b1, 8'h00, c == "+" ? TOK_INCREMENT : TOK_A_INCR);
                  lx_mode = M_IDLE;
                  return 1'b1;
               end
               push_result(1'b1, 8'h00, TOK_PLUS);
            end else begin
               if (c == "-" || c == "=" || c == ">") begin
                  push_result(1'b0, c, 6'd0);
                  push_result(1'b1, 8'h00, c == "-" ? TOK_DECREMENT :
                                           c == "=" ? TOK_A_DECR : TOK_ARROW);
                  lx_mode = M_IDLE;
                  return 1'b1;
               end
               push_result(1'b1, 8'h00, TOK_MINUS);
            end
         end
         default: ;
      endcase
      lx_mode = M_IDLE;
      return 1'b0;
   endfunction

   // expected results of one accepted source byte
   function automatic void lex_byte(logic [7:0] c);
      int due_prior;
      int guard;
      due_prior = tokens_due.size();
      guard = 0;
      while (!lex_pass(c) && guard < 8) guard++;
      if (c != 8'h00) begin
         if (c == 8'h0a) begin
            if (lx_line != 16'hffff) lx_line++;
            lx_col = 1;
         end else if (lx_col != 12'hfff) lx_col++;
      end
      if (tokens_due.size() > due_prior) tokens_due[$].last = 1'b1;
   endfunction

   // ------------------------------------------------------------------
   // result checker
   // ------------------------------------------------------------------
   lex_result_type got, want;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_result_kind, rsp_text_char, rsp_token_type,
                 rsp_token_line, rsp_token_column, rsp_last_of_run};
         results_seen++;
         if (rsp_result_kind) tokens_seen++;
         if (tokens_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", got);
         end else begin
            want = tokens_due.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
            end
         end
      end
   end

   // receiver stall, redrawn every cycle
   always @(negedge clock) rsp_stall <= ($urandom_range(99) < recv_idle_pct);

   // ------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------
   task automatic send_char(input logic [7:0] c);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         req_source_char = 8'($urandom);   // garbage while idle
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_source_char = c;
      do @(posedge clock); while (req_stall);
      lex_byte(c);
      chars_sent++;
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i]);
   endtask

   task automatic wait_drained();
      while (tokens_due.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------
   task automatic keyword_test();
      send_text("struct typedef float int char void long unsigned structs _a9Z ");
      send_text("abcdefghijklmnopqrstuvw unsignedx\n");
   endtask

   task automatic literal_test();
      // strings with known and unknown escapes, char literals good and broken
      send_text("\"a\\n\\t\\r\\q\\\\\" 'x' '\\n' '\\'' 'ab' ");
      send_text("0 12 3.5 7f 2.5F 9. 1.2.3 .5 .5f ");
   endtask

   task automatic symbol_test();
      send_text("... .. . .x ..x ++ += + -- -= -> - , / * % ( ) { } [ ] @ #");
      send_char(8'h80);
      send_char(8'hff);
      send_char(8'h01);
      send_char(8'h00);
   endtask

   // end of source inside open strings, char literals, escapes, an identifier, a dot pair and a minus
   task automatic end_of_source_test();
      send_text("\"ab\\"); send_char(8'h00);
      send_text("'\\");    send_char(8'h00);
      send_text("'");      send_char(8'h00);
      send_text("'z");     send_char(8'h00);
      send_text("\"abc");  send_char(8'h00);
      send_text("ident");  send_char(8'h00);
      send_text("..");     send_char(8'h00);
      send_text("-");      send_char(8'h00);
      send_char(8'h00);
   endtask

   function automatic logic [7:0] pick_ident_char(input logic first);
      int r;
      r = $urandom_range(first ? 52 : 62);
      if (r < 26) return "a" + 8'(r);
      if (r < 52) return "A" + 8'(r - 26);
      if (r < 62) return "0" + 8'(r - 52);
      return "_";
   endfunction

   task automatic random_stream(input int count, input int s_pct, input int r_pct);
      int stop_at;
      int len;
      logic [7:0] c;
      string syms [14] = '{",", "/", "*", "%", "(", ")", "{", "}", "[", "]",
                          "++", "+=", "--", "->"};
      string str_esc = "ntr";
      string chr_esc = "ntr'";
      stop_at = chars_sent + count;
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      while (chars_sent < stop_at) begin
         case ($urandom_range(15))
            0, 1, 2: begin
               len = $urandom_range(1, 12);
               for (int i = 0; i < len; i++) send_char(pick_ident_char(i == 0));
            end
            3: send_text(keywords[$urandom_range(7)]);
            4, 5: begin
               len = $urandom_range(1, 4);
               if ($urandom_range(3) == 0) send_char(".");
               else for (int i = 0; i < len; i++) send_char("0" + 8'($urandom_range(9)));
               if ($urandom_range(1)) begin
                  send_char(".");
                  for (int i = 0; i < len; i++) send_char("0" + 8'($urandom_range(9)));
               end
               if ($urandom_range(2) == 0) send_char($urandom_range(1) ? "f" : "F");
            end
            6, 7: begin
               send_char("\"");
               len = $urandom_range(0, 6);
               for (int i = 0; i < len; i++) begin
                  if ($urandom_range(3) == 0) begin
                     send_char("\\");
                     c = 8'($urandom_range(1, 255));
                     send_char($urandom_range(1) ? c : str_esc[$urandom_range(2)]);
                  end else begin
                     c = 8'($urandom_range(1, 255));
                     send_char(c == "\"" || c == "\\" ? "s" : c);
                  end
               end
               if ($urandom_range(7) != 0) send_char("\"");
            end
            8: begin
               send_char("'");
               if ($urandom_range(2) == 0) begin
                  send_char("\\");
                  send_char(chr_esc[$urandom_range(3)]);
               end else send_char(8'($urandom_range(32, 126)));
               if ($urandom_range(7) != 0) send_char("'");
            end
            9, 10, 11: send_text(syms[$urandom_range(13)]);
            12: send_text($urandom_range(1) ? "..." : "..");
            13: send_char(8'($urandom));          // raw noise, any byte
            14: send_char($urandom_range(1) ? "+" : "-");
            15: if ($urandom_range(3) == 0) send_char(8'h00);
         endcase
         // separator: mostly blanks, sometimes tokens run together
         case ($urandom_range(5))
            0:       ;
            1:       send_char(8'h0a);
            2:       send_char(8'h09);
            default: send_char(" ");
         endcase
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      keyword_test();
      literal_test();
      symbol_test();
      end_of_source_test();
      wait_drained();

      random_stream(45, 22, 64);
      wait_drained();                  // sender holds until the block is empty
      random_stream(45, 64, 22);
      random_stream(40, 0, 0);
      send_char(8'h00);
      send_idle_pct = 0;

      wait_drained();
      recv_idle_pct = 0;
      repeat (20) @(posedge clock);

      $display("Sent %0d source bytes: keywords, literals, escapes, punctuators,", chars_sent);
      $display("broken tokens, random streams; checked %0d results, %0d tokens.",
               results_seen, tokens_seen);
      if (mismatches == 0 && tokens_due.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatches, tokens_due.size());
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
